// ===== design/calibration_confidence_state_fsm_defines.svh =====
// ----------------------------------------------------------------------------
// Calibration confidence state machine: assertion macros
// Shared assertion shorthands, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef CALIBRATION_CONFIDENCE_STATE_FSM_DEFINES_SVH
`define CALIBRATION_CONFIDENCE_STATE_FSM_DEFINES_SVH

// Same-cycle implication.
`define CCSF_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define CCSF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/ccsf_pkg.sv =====
// ----------------------------------------------------------------------------
// Calibration confidence state machine: package
// Codes, types and constants for the confidence state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package ccsf_pkg;

    // Confidences are percentages and saturate here.
    localparam logic [6:0] CONF_MAX = 7'd100;

    // Working type for threshold arithmetic; wide enough that nothing wraps.
    typedef logic signed [8:0] th_calc_t;

    localparam th_calc_t THRESHOLD_DELTA = 9'sd10;
    localparam th_calc_t CONF_MAX_S      = 9'sd100;

    typedef enum logic [1:0] {
        ST_GOOD  = 2'd0,
        ST_UNVAL = 2'd1,
        ST_SUSP  = 2'd2,
        ST_BAD   = 2'd3
    } calib_state_t;

    typedef enum logic [1:0] {
        LV_LOW  = 2'd0,
        LV_MED  = 2'd1,
        LV_HIGH = 2'd2,
        LV_HSTR = 2'd3
    } conf_level_t;

    typedef enum logic [1:0] {
        MODE_CLASSIC = 2'd0,
        MODE_SIMPLE  = 2'd1,
        MODE_MEMORY  = 2'd2,
        MODE_DWELL   = 2'd3
    } machine_mode_t;

    typedef enum logic [2:0] {
        CFG_MACHINE_MODE    = 3'd0,
        CFG_MIN_HIGH_TH     = 3'd1,
        CFG_MAX_HIGH_TH     = 3'd2,
        CFG_THRESHOLD_STEP  = 3'd3,
        CFG_STRINGENT_INIT  = 3'd4,
        CFG_LOW_TH          = 3'd5,
        CFG_START_DELAY     = 3'd6,
        CFG_SUSPECT_TIME    = 3'd7
    } cfg_index_t;

endpackage

`default_nettype wire

// ===== design/calibration_confidence_state_fsm.sv =====
// Words pass through an input register and an output register. Throughput: one
// word per cycle unless the output is held. While a result waits downstream, one
// more word is taken into the empty input register; s_tready then stays low
// until it moves. The whole per-frame update is one pass of compares and clamps.
// Reset (aresetn, synchronous, active low) restores the register defaults and
// the machine state at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Calibration confidence state machine
// Per-frame calibration state from confidence inputs, four selectable machines.
// ----------------------------------------------------------------------------
`default_nettype none

`include "calibration_confidence_state_fsm_defines.svh"

module calibration_confidence_state_fsm (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [7:0]  cfg_wdata,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata: confidence[6:0], stringent_confidence[13:7], in_range[14],
    //          stable_signal[15], frame_index[31:16], degrade_cause_in[35:32]
    input  wire logic [39:0] s_tdata,
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: calib_state[1:0], degrade_cause[5:2], conf_level[7:6],
    //          high_threshold_now[14:8], stringent_threshold_now[21:15]
    output logic [23:0]      m_tdata
);

    // Configuration registers
    ccsf_pkg::machine_mode_t mode_reg;
    logic [6:0] min_high_reg;
    logic [6:0] max_high_reg;
    logic [6:0] step_reg;
    logic [6:0] str_init_reg;
    logic [6:0] low_th_reg;
    logic [7:0] start_delay_reg;
    logic [7:0] suspect_time_reg;

    // Machine state
    logic [6:0] high_th_reg, high_th_next;
    logic [6:0] str_th_reg, str_th_next;
    logic       was_high_reg, was_high_next;
    ccsf_pkg::conf_level_t  level_reg, level_next;
    logic [7:0] level_dwell_reg, level_dwell_next;
    logic [7:0] state_dwell_reg, state_dwell_next;
    ccsf_pkg::calib_state_t inner_reg, inner_next;
    ccsf_pkg::calib_state_t last_reg, last_next;

    // Pipeline
    logic        in_valid_reg;
    logic [35:0] in_data_reg;
    logic        out_valid_reg;
    logic [21:0] out_data_reg;
    logic        advance;

    // Decoded input word
    logic [6:0]  raw_conf, raw_sconf;
    logic [6:0]  conf, sconf;
    logic        in_range, stable;
    logic [15:0] frame;
    logic [3:0]  cause_in;

    // Step result
    ccsf_pkg::calib_state_t st;
    logic [3:0]             cause;
    logic [7:0]             dwell_cap;

    function automatic ccsf_pkg::th_calc_t to_th(input logic [6:0] v);
        return $signed({2'b00, v});
    endfunction

    function automatic ccsf_pkg::th_calc_t smax(input ccsf_pkg::th_calc_t a,
                                                input ccsf_pkg::th_calc_t b);
        return (a > b) ? a : b;
    endfunction

    function automatic ccsf_pkg::th_calc_t smin(input ccsf_pkg::th_calc_t a,
                                                input ccsf_pkg::th_calc_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] dwell_step(input logic same, input logic [7:0] cnt,
                                              input logic [7:0] cap);
        logic [8:0] n;
        n = same ? ({1'b0, cnt} + 9'd1) : 9'd0;
        return (n < {1'b0, cap}) ? n[7:0] : cap;
    endfunction

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    assign raw_conf  = in_data_reg[6:0];
    assign raw_sconf = in_data_reg[13:7];
    assign in_range  = in_data_reg[14];
    assign stable    = in_data_reg[15];
    assign frame     = in_data_reg[31:16];
    assign cause_in  = in_data_reg[35:32];
    assign conf      = (raw_conf  > ccsf_pkg::CONF_MAX) ? ccsf_pkg::CONF_MAX : raw_conf;
    assign sconf     = (raw_sconf > ccsf_pkg::CONF_MAX) ? ccsf_pkg::CONF_MAX : raw_sconf;
    assign dwell_cap = (suspect_time_reg > start_delay_reg) ? suspect_time_reg
                                                            : start_delay_reg;

    // Next-state logic for one frame.
    always_comb begin
        ccsf_pkg::th_calc_t ht_s, str_s, step_s, min_s, max_s;
        ccsf_pkg::th_calc_t str_lo, str_hi, hi_hi;
        ccsf_pkg::conf_level_t lvl;
        ccsf_pkg::calib_state_t inner;
        logic [7:0] ldw, sdw;
        logic exit_bad, exit_sus;

        ht_s   = to_th(high_th_reg);
        str_s  = to_th(str_th_reg);
        step_s = to_th(step_reg);
        min_s  = to_th(min_high_reg);
        max_s  = to_th(max_high_reg);
        str_lo = to_th(str_init_reg);
        str_hi = smin(str_lo + ccsf_pkg::THRESHOLD_DELTA, ccsf_pkg::CONF_MAX_S);
        hi_hi  = smin(min_s + ccsf_pkg::THRESHOLD_DELTA, str_lo);
        lvl    = ccsf_pkg::LV_LOW;
        inner  = inner_reg;
        ldw    = level_dwell_reg;
        sdw    = state_dwell_reg;
        exit_bad = 1'b0;
        exit_sus = 1'b0;

        high_th_next     = high_th_reg;
        str_th_next      = str_th_reg;
        was_high_next    = was_high_reg;
        level_next       = level_reg;
        level_dwell_next = level_dwell_reg;
        state_dwell_next = state_dwell_reg;
        inner_next       = inner_reg;
        st               = ccsf_pkg::ST_UNVAL;

        unique case (mode_reg)
            ccsf_pkg::MODE_CLASSIC: begin
                if (conf > high_th_reg) begin
                    st = in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_UNVAL;
                    high_th_next = 7'(smax(min_s, ht_s - step_s));
                    was_high_next = 1'b1;
                end else begin
                    st = (conf > low_th_reg) ? ccsf_pkg::ST_UNVAL : ccsf_pkg::ST_SUSP;
                    if (was_high_reg) begin
                        high_th_next = 7'(smin(max_s, ht_s + step_s));
                    end
                end
                if (sconf > min_high_reg && !in_range) begin
                    st = ccsf_pkg::ST_BAD;
                end
            end
            ccsf_pkg::MODE_SIMPLE: begin
                // During ride start the state is forced to unvalidated.
                if (frame > {8'd0, start_delay_reg}) begin
                    if (conf > high_th_reg) begin
                        st = in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_UNVAL;
                        was_high_next = 1'b1;
                    end else begin
                        st = (conf > low_th_reg) ? ccsf_pkg::ST_UNVAL : ccsf_pkg::ST_SUSP;
                    end
                    if (sconf > str_th_reg && !in_range) begin
                        st = ccsf_pkg::ST_BAD;
                    end
                end
            end
            ccsf_pkg::MODE_MEMORY: begin
                if (sconf > str_th_reg) begin
                    lvl = ccsf_pkg::LV_HSTR;
                end else if (conf > high_th_reg) begin
                    lvl = ccsf_pkg::LV_HIGH;
                end else if (conf > low_th_reg) begin
                    lvl = ccsf_pkg::LV_MED;
                end else begin
                    lvl = ccsf_pkg::LV_LOW;
                end
                ldw = dwell_step(lvl == level_reg, level_dwell_reg, dwell_cap);
                unique case (lvl)
                    ccsf_pkg::LV_HSTR: st = in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_BAD;
                    ccsf_pkg::LV_HIGH: st = in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_UNVAL;
                    ccsf_pkg::LV_MED:
                        st = (ldw < suspect_time_reg) ? last_reg : ccsf_pkg::ST_SUSP;
                    ccsf_pkg::LV_LOW:
                        st = (ldw < start_delay_reg) ? last_reg : ccsf_pkg::ST_UNVAL;
                endcase
                // Bad is left only for good.
                if (last_reg == ccsf_pkg::ST_BAD && st != ccsf_pkg::ST_GOOD) begin
                    st = ccsf_pkg::ST_BAD;
                end
                level_next       = lvl;
                level_dwell_next = ldw;
                state_dwell_next = dwell_step(last_reg == st, state_dwell_reg, dwell_cap);
            end
            ccsf_pkg::MODE_DWELL: begin
                if (conf > str_th_reg) begin
                    lvl = ccsf_pkg::LV_HSTR;
                    str_th_next = 7'(smin(str_s + step_s, str_hi));
                end else if (conf >= high_th_reg) begin
                    lvl = ccsf_pkg::LV_HIGH;
                    str_th_next  = 7'(smax(str_s - step_s, str_lo));
                    high_th_next = 7'(smax(ht_s - step_s, min_s));
                end else begin
                    lvl = ccsf_pkg::LV_LOW;
                    high_th_next = 7'(smin(ht_s + step_s, hi_hi));
                end
                ldw = dwell_step(lvl == level_reg, level_dwell_reg, dwell_cap);
                if (lvl == ccsf_pkg::LV_HSTR) begin
                    inner = in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_BAD;
                end else if (lvl == ccsf_pkg::LV_HIGH) begin
                    inner = in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_UNVAL;
                end else begin
                    inner = (ldw < start_delay_reg) ? last_reg : ccsf_pkg::ST_UNVAL;
                end
                // Suspected and bad are sticky until a clean exit condition.
                if (last_reg == ccsf_pkg::ST_BAD || last_reg == ccsf_pkg::ST_SUSP) begin
                    exit_bad = inner == ccsf_pkg::ST_GOOD && lvl == ccsf_pkg::LV_HSTR &&
                               last_reg == ccsf_pkg::ST_BAD;
                    exit_sus = inner == ccsf_pkg::ST_GOOD && last_reg == ccsf_pkg::ST_SUSP;
                    if (!(exit_bad || exit_sus)) begin
                        inner = last_reg;
                    end
                end
                if (!stable && inner != ccsf_pkg::ST_BAD) begin
                    inner = ccsf_pkg::ST_SUSP;
                end
                sdw = dwell_step(inner_reg == inner, state_dwell_reg, dwell_cap);
                st  = (inner == ccsf_pkg::ST_BAD || sdw > suspect_time_reg) ? inner : last_reg;
                level_next       = lvl;
                level_dwell_next = ldw;
                state_dwell_next = sdw;
                inner_next       = inner;
            end
        endcase

        last_next = st;
    end

    // Output word contents.
    always_comb begin
        cause = ((st > last_reg) && (st != ccsf_pkg::ST_BAD)) ? cause_in : 4'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= ccsf_pkg::MODE_DWELL;
            min_high_reg     <= 7'd20;
            max_high_reg     <= 7'd85;
            step_reg         <= 7'd1;
            str_init_reg     <= 7'd70;
            low_th_reg       <= 7'd7;
            start_delay_reg  <= 8'd10;
            suspect_time_reg <= 8'd3;
            high_th_reg      <= 7'd20;
            str_th_reg       <= 7'd70;
            was_high_reg     <= 1'b0;
            level_reg        <= ccsf_pkg::LV_LOW;
            level_dwell_reg  <= 8'd0;
            state_dwell_reg  <= 8'd0;
            inner_reg        <= ccsf_pkg::ST_UNVAL;
            last_reg         <= ccsf_pkg::ST_UNVAL;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg   <= 1'b1;
                high_th_reg     <= high_th_next;
                str_th_reg      <= str_th_next;
                was_high_reg    <= was_high_next;
                level_reg       <= level_next;
                level_dwell_reg <= level_dwell_next;
                state_dwell_reg <= state_dwell_next;
                inner_reg       <= inner_next;
                last_reg        <= last_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            // Writing a threshold floor also restarts that adaptive threshold.
            if (cfg_we) begin
                unique case (ccsf_pkg::cfg_index_t'(cfg_addr))
                    ccsf_pkg::CFG_MACHINE_MODE:
                        mode_reg <= ccsf_pkg::machine_mode_t'(cfg_wdata[1:0]);
                    ccsf_pkg::CFG_MIN_HIGH_TH: begin
                        min_high_reg <= cfg_wdata[6:0];
                        high_th_reg  <= cfg_wdata[6:0];
                    end
                    ccsf_pkg::CFG_MAX_HIGH_TH:    max_high_reg <= cfg_wdata[6:0];
                    ccsf_pkg::CFG_THRESHOLD_STEP: step_reg     <= cfg_wdata[6:0];
                    ccsf_pkg::CFG_STRINGENT_INIT: begin
                        str_init_reg <= cfg_wdata[6:0];
                        str_th_reg   <= cfg_wdata[6:0];
                    end
                    ccsf_pkg::CFG_LOW_TH:       low_th_reg       <= cfg_wdata[6:0];
                    ccsf_pkg::CFG_START_DELAY:  start_delay_reg  <= cfg_wdata;
                    ccsf_pkg::CFG_SUSPECT_TIME: suspect_time_reg <= cfg_wdata;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata[35:0];
        end
        if (advance) begin
            out_data_reg <= {str_th_next, high_th_next, 2'(level_next), cause, 2'(st)};
        end
    end

    `CCSF_ASSERT_NEXT(a_accept_fills_input, aclk, aresetn, s_tvalid && s_tready, in_valid_reg)
    `CCSF_ASSERT_NEXT(a_advance_gives_result, aclk, aresetn, advance, out_valid_reg)
    `CCSF_ASSERT_SAME(a_no_cause_when_bad, aclk, aresetn,
        out_valid_reg && out_data_reg[1:0] == ccsf_pkg::ST_BAD, out_data_reg[5:2] == 4'd0)
    `CCSF_ASSERT_NEXT(a_last_state_is_reported, aclk, aresetn, advance,
        out_data_reg[1:0] == last_reg)

endmodule

`default_nettype wire

// ===== verif/calibration_confidence_state_fsm_test.sv =====
// ----------------------------------------------------------------------------
// Calibration confidence state machine: stream testbench
// Drives frame words through all four machines under changing register
// settings, predicts every result word and checks it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module calibration_confidence_state_fsm_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RAND_PHASES  = 12;
    localparam int PHASE_WORDS  = 103;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        logic [3:0]  cause;
        logic [15:0] frame;
        logic        stable;
        logic        in_range;
        logic [6:0]  sconf;
        logic [6:0]  conf;
    } frame_word_t;

    typedef struct {
        ccsf_pkg::calib_state_t st;
        logic [3:0]             cause;
        ccsf_pkg::conf_level_t  lvl;
        logic [6:0]             hth;
        logic [6:0]             sth;
    } calib_result_t;

    class calib_scoreboard;
        ccsf_pkg::machine_mode_t mode_sel;
        int min_hi, max_hi, step, str_init, low_th, start_delay, suspect_time;
        int hi_th, str_th;
        bit was_high;
        ccsf_pkg::conf_level_t level;
        int level_dwell, state_dwell;
        ccsf_pkg::calib_state_t inner, last;
        calib_result_t expected_q[$];
        int mismatches;

        function new();
            mode_sel     = ccsf_pkg::MODE_DWELL;
            min_hi       = 20;
            max_hi       = 85;
            step         = 1;
            str_init     = 70;
            low_th       = 7;
            start_delay  = 10;
            suspect_time = 3;
            hi_th        = min_hi;
            str_th       = str_init;
            was_high     = 1'b0;
            level        = ccsf_pkg::LV_LOW;
            level_dwell  = 0;
            state_dwell  = 0;
            inner        = ccsf_pkg::ST_UNVAL;
            last         = ccsf_pkg::ST_UNVAL;
            mismatches   = 0;
        endfunction

        function int min_of(int a, int b);
            return a < b ? a : b;
        endfunction

        function int max_of(int a, int b);
            return a > b ? a : b;
        endfunction

        function void write_reg(ccsf_pkg::cfg_index_t idx, logic [7:0] val);
            case (idx)
                ccsf_pkg::CFG_MACHINE_MODE:
                    mode_sel = ccsf_pkg::machine_mode_t'(val[1:0]);
                ccsf_pkg::CFG_MIN_HIGH_TH: begin
                    min_hi = val[6:0];
                    hi_th  = min_hi;
                end
                ccsf_pkg::CFG_MAX_HIGH_TH:    max_hi = val[6:0];
                ccsf_pkg::CFG_THRESHOLD_STEP: step = val[6:0];
                ccsf_pkg::CFG_STRINGENT_INIT: begin
                    str_init = val[6:0];
                    str_th   = str_init;
                end
                ccsf_pkg::CFG_LOW_TH:         low_th = val[6:0];
                ccsf_pkg::CFG_START_DELAY:    start_delay = val;
                ccsf_pkg::CFG_SUSPECT_TIME:   suspect_time = val;
                default: ;
            endcase
        endfunction

        // Both dwell counters stop at the larger of the two dwell settings.
        function int dwell_next(bit same, int cnt);
            return min_of(same ? cnt + 1 : 0, max_of(suspect_time, start_delay));
        endfunction

        function void note_word(frame_word_t w);
            int c, sc, str_lo, str_hi, hi_lo, hi_hi;
            ccsf_pkg::calib_state_t st, prev_inner;
            ccsf_pkg::conf_level_t prev_level;
            bit exit_bad, exit_sus;
            calib_result_t r;
            c  = min_of(w.conf, 100);
            sc = min_of(w.sconf, 100);
            st = ccsf_pkg::ST_UNVAL;
            r.cause = 4'd0;
            case (mode_sel)
                ccsf_pkg::MODE_CLASSIC: begin
                    if (c > hi_th) begin
                        st       = w.in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_UNVAL;
                        hi_th    = max_of(min_hi, hi_th - step);
                        was_high = 1'b1;
                    end else begin
                        st = c > low_th ? ccsf_pkg::ST_UNVAL : ccsf_pkg::ST_SUSP;
                        if (was_high)
                            hi_th = min_of(max_hi, hi_th + step);
                    end
                    // The stringent confidence is weighed against the minimum high
                    // threshold in this machine.
                    if (sc > min_hi && !w.in_range)
                        st = ccsf_pkg::ST_BAD;
                end
                ccsf_pkg::MODE_SIMPLE: begin
                    if (w.frame > start_delay) begin
                        if (c > hi_th) begin
                            st       = w.in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_UNVAL;
                            was_high = 1'b1;
                        end else begin
                            st = c > low_th ? ccsf_pkg::ST_UNVAL : ccsf_pkg::ST_SUSP;
                        end
                        if (sc > str_th && !w.in_range)
                            st = ccsf_pkg::ST_BAD;
                    end
                end
                ccsf_pkg::MODE_MEMORY: begin
                    prev_level = level;
                    if (sc > str_th)
                        level = ccsf_pkg::LV_HSTR;
                    else if (c > hi_th)
                        level = ccsf_pkg::LV_HIGH;
                    else if (c > low_th)
                        level = ccsf_pkg::LV_MED;
                    else
                        level = ccsf_pkg::LV_LOW;
                    level_dwell = dwell_next(level == prev_level, level_dwell);
                    case (level)
                        ccsf_pkg::LV_HSTR:
                            st = w.in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_BAD;
                        ccsf_pkg::LV_HIGH:
                            st = w.in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_UNVAL;
                        ccsf_pkg::LV_MED:
                            st = level_dwell < suspect_time ? last : ccsf_pkg::ST_SUSP;
                        default:
                            st = level_dwell < start_delay ? last : ccsf_pkg::ST_UNVAL;
                    endcase
                    if (last == ccsf_pkg::ST_BAD && st != ccsf_pkg::ST_GOOD)
                        st = ccsf_pkg::ST_BAD;
                    state_dwell = dwell_next(last == st, state_dwell);
                end
                default: begin
                    prev_inner = inner;
                    prev_level = level;
                    str_lo = str_init;
                    str_hi = min_of(str_lo + int'(ccsf_pkg::THRESHOLD_DELTA), 100);
                    hi_lo  = min_hi;
                    hi_hi  = min_of(hi_lo + int'(ccsf_pkg::THRESHOLD_DELTA), str_lo);
                    if (c > str_th) begin
                        level  = ccsf_pkg::LV_HSTR;
                        str_th = min_of(str_th + step, str_hi);
                    end else if (c >= hi_th) begin
                        level  = ccsf_pkg::LV_HIGH;
                        str_th = max_of(str_th - step, str_lo);
                        hi_th  = max_of(hi_th - step, hi_lo);
                    end else begin
                        level = ccsf_pkg::LV_LOW;
                        hi_th = min_of(hi_th + step, hi_hi);
                    end
                    level_dwell = dwell_next(level == prev_level, level_dwell);
                    if (level == ccsf_pkg::LV_HSTR)
                        inner = w.in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_BAD;
                    else if (level == ccsf_pkg::LV_HIGH)
                        inner = w.in_range ? ccsf_pkg::ST_GOOD : ccsf_pkg::ST_UNVAL;
                    else
                        inner = level_dwell < start_delay ? last : ccsf_pkg::ST_UNVAL;
                    // Bad is left only on a stringent-level good frame, suspected on
                    // any good frame.
                    if (last == ccsf_pkg::ST_BAD || last == ccsf_pkg::ST_SUSP) begin
                        exit_bad = inner == ccsf_pkg::ST_GOOD && level == ccsf_pkg::LV_HSTR &&
                                   last == ccsf_pkg::ST_BAD;
                        exit_sus = inner == ccsf_pkg::ST_GOOD && last == ccsf_pkg::ST_SUSP;
                        if (!(exit_bad || exit_sus))
                            inner = last;
                    end
                    if (!w.stable && inner != ccsf_pkg::ST_BAD)
                        inner = ccsf_pkg::ST_SUSP;
                    state_dwell = dwell_next(prev_inner == inner, state_dwell);
                    st = (inner == ccsf_pkg::ST_BAD || state_dwell > suspect_time) ? inner
                                                                                   : last;
                end
            endcase
            if (st > last && st != ccsf_pkg::ST_BAD)
                r.cause = w.cause;
            last  = st;
            r.st  = st;
            r.lvl = level;
            r.hth = 7'(hi_th);
            r.sth = 7'(str_th);
            expected_q = {expected_q, r};
        endfunction

        function void report(string what, int exp, int act);
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display("%t mismatch in %s: expected %0d, got %0d", $realtime, what, exp, act);
        endfunction

        function void check_result(logic [23:0] d);
            calib_result_t e;
            if (expected_q.size() == 0) begin
                report("unexpected result word", 0, int'(d));
                return;
            end
            e = expected_q.pop_front();
            if (d[1:0] != e.st)    report("calib_state", e.st, d[1:0]);
            if (d[5:2] != e.cause) report("degrade_cause", e.cause, d[5:2]);
            if (d[7:6] != e.lvl)   report("conf_level", e.lvl, d[7:6]);
            if (d[14:8] != e.hth)  report("high_threshold_now", e.hth, d[14:8]);
            if (d[21:15] != e.sth) report("stringent_threshold_now", e.sth, d[21:15]);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    calib_scoreboard sb = new();

    bit calm;
    int rx_hold_left;
    int quiet_cycles;
    int run_left;
    int run_level;

    calibration_confidence_state_fsm uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Downstream side: random back-pressure, or a counted hold-off when asked.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_left > 0) begin
                m_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("calibration_confidence_state_fsm_test: errors");
            $finish;
        end
    end

    // Offers one word and returns at the edge that takes it; tvalid stays high so
    // that a following word can go out back to back when no gap is drawn.
    task automatic send_word(frame_word_t w);
        while (!calm && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, w};
        do
            @(posedge aclk);
        while (!s_tready);
        sb.note_word(w);
    endtask

    task automatic send_fields(int c, int sc, bit ir, bit stb, int fr, int cause);
        frame_word_t w;
        w.conf     = 7'(c);
        w.sconf    = 7'(sc);
        w.in_range = ir;
        w.stable   = stb;
        w.frame    = 16'(fr);
        w.cause    = 4'(cause);
        send_word(w);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.pending() != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(ccsf_pkg::cfg_index_t idx, logic [7:0] val);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_setting(int top, int usual_top);
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'(top);
            default: return 8'($urandom_range(0, usual_top));
        endcase
    endfunction

    // Confidence moves in runs around a level so that the dwell counters fill up
    // and the smoothed machines settle; odd words break the runs.
    function automatic frame_word_t random_word();
        frame_word_t w;
        int c;
        if (run_left == 0) begin
            run_left  = $urandom_range(1, 16);
            run_level = $urandom_range(0, 100);
        end
        run_left--;
        c = run_level + int'($urandom_range(0, 6)) - 3;
        c = c < 0 ? 0 : (c > 100 ? 100 : c);
        if ($urandom_range(0, 11) == 0)
            c = $urandom_range(0, 127);
        w.conf     = 7'(c);
        w.sconf    = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                                 : 7'($urandom_range(0, c));
        w.in_range = $urandom_range(0, 99) < 82;
        w.stable   = $urandom_range(0, 99) < 90;
        w.frame    = $urandom_range(0, 1) ? 16'($urandom_range(0, 2 * sb.start_delay + 2))
                                          : 16'($urandom);
        w.cause    = 4'($urandom);
        return w;
    endfunction

    initial begin
        logic [7:0] v;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        calm         = 1'b0;
        rx_hold_left = 0;
        quiet_cycles = 0;
        run_left     = 0;
        run_level    = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Dwell-smoothed machine straight out of reset, with saturating inputs
        // and an unstable signal.
        send_fields(0, 0, 1, 1, 0, 0);
        send_fields(127, 127, 1, 1, 16'hffff, 15);
        send_fields(100, 50, 0, 1, 3, 5);
        send_fields(50, 10, 1, 0, 4, 6);
        send_fields(21, 0, 1, 1, 5, 7);

        // Classic hysteresis; the stringent test uses the minimum high threshold.
        write_reg(ccsf_pkg::CFG_MACHINE_MODE, 8'(ccsf_pkg::MODE_CLASSIC));
        send_fields(127, 0, 1, 1, 0, 1);
        send_fields(5, 0, 1, 1, 0, 9);
        send_fields(50, 90, 0, 1, 0, 2);
        send_fields(101, 0, 0, 1, 0, 4);

        // Plain thresholds around the end of the ride start.
        write_reg(ccsf_pkg::CFG_MACHINE_MODE, 8'(ccsf_pkg::MODE_SIMPLE));
        send_fields(100, 0, 1, 1, 10, 8);
        send_fields(100, 0, 1, 1, 11, 8);
        send_fields(100, 0, 1, 1, 0, 8);
        send_fields(3, 0, 1, 1, 500, 3);
        send_fields(110, 110, 0, 1, 500, 12);

        // Thresholds with memory: stringent bad, a good high frame, then a medium
        // run long enough to suspect, then a low run.
        write_reg(ccsf_pkg::CFG_MACHINE_MODE, 8'(ccsf_pkg::MODE_MEMORY));
        send_fields(100, 100, 0, 1, 0, 10);
        send_fields(50, 0, 1, 1, 0, 11);
        repeat (4) send_fields(10, 0, 1, 1, 0, 13);
        repeat (3) send_fields(0, 0, 1, 1, 0, 14);

        for (int p = 0; p < RAND_PHASES; p++) begin
            write_reg(ccsf_pkg::CFG_MACHINE_MODE, 8'(ccsf_pkg::machine_mode_t'(p % 4)));
            for (int r = 1; r <= 7; r++) begin
                if (p == 1)
                    v = 8'd0;
                else if (p == 2)
                    v = (r >= 6) ? 8'd255 : 8'd100;
                else if (r == 3)
                    v = pick_setting(100, 8);
                else if (r >= 6)
                    v = pick_setting(255, 12);
                else
                    v = pick_setting(100, 100);
                write_reg(ccsf_pkg::cfg_index_t'(r), v);
            end
            if (p == 3)
                rx_hold_left = 300;
            calm = (p == 6);
            for (int i = 0; i < PHASE_WORDS; i++)
                send_word(random_word());
        end

        calm = 1'b0;
        wait_drained();
        repeat (4) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("calibration_confidence_state_fsm_test: clean");
        else
            $display("calibration_confidence_state_fsm_test: errors");
        $finish;
    end

endmodule

`default_nettype wire
